### hw/rtl/dlmo_pkg.sv
// Package for the dual logistic map oscillator.
// Holds the sequencer state type and the multiply slot codes; no dependencies.
`default_nettype none

package dlmo_pkg;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CLIP = 8'b0000_0010,
    ST_PREP = 8'b0000_0100,
    ST_LOAD = 8'b0000_1000,
    ST_MAG  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  // Order of the four multiplications of one beat.
  typedef enum logic [1:0] {
    OP_ONE_RATE  = 2'd0,
    OP_ONE_SCALE = 2'd1,
    OP_TWO_RATE  = 2'd2,
    OP_TWO_SCALE = 2'd3
  } op_t;

endpackage

`default_nettype wire

### hw/rtl/dlmo_if.sv
// Valid/ready channel interfaces for the dual logistic map oscillator.
// Input channel carries rate, seed and offset; output channel both trajectories.
`default_nettype none

interface dlmo_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] growth_rate;
  logic signed [WORD_BITS-1:0] start_value;
  logic signed [WORD_BITS-1:0] offset_value;

  modport source (output valid, output growth_rate, output start_value,
                  output offset_value, input ready);
  modport sink (input valid, input growth_rate, input start_value,
                input offset_value, output ready);
endinterface

interface dlmo_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] trajectory_one;
  logic signed [WORD_BITS-1:0] trajectory_two;

  modport source (output valid, output trajectory_one, output trajectory_two,
                  input ready);
  modport sink (input valid, input trajectory_one, input trajectory_two,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/dual_logistic_map_oscillator.sv
// Dual logistic map oscillator top level: sequencer around one shared multiplier.
// Depends on dlmo_pkg and the channel interfaces in dlmo_if.sv.
//
// Usage. Each input beat carries a growth rate, a seed and an offset in signed
// fixed point with FRACTION_BITS fraction bits. The rate is clipped to 3.5..4.0
// and the seed to 0.000001..0.999999. On the first beat after reset, or when the
// clipped seed or the raw offset changes, trajectory one restarts at the seed and
// trajectory two at the clipped seed plus offset, held within -0.999999..0.999999.
// Both then take one logistic step and one output beat carries the two new values.
// Sequence: an accepted item is clipped and set up, then goes through the four
// multiplications, each done on one half-width multiplier as four partial
// products, with operand set-up and rounding steps around each, before it moves
// to the output register. in_ch.ready stays low from acceptance until then, so a
// new beat is taken only once the last one has reached the output register.
// Reset (synchronous, active low) returns both trajectories and the last seed
// to one half, clears the last offset and forgets that any beat was seen.
// A stalled receiver holds the output register; the next input beat is still
// taken and worked, and its result waits until the register is free.
`default_nettype none

module dual_logistic_map_oscillator #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 28
) (
  input  wire          clk,
  input  wire          rst_n,
  dlmo_in_if.sink      in_ch,
  dlmo_out_if.source   out_ch
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int H  = (W + 1) / 2;
  localparam int AW = 4 * H;
  localparam int QW = AW - F;

  localparam logic [63:0] ONE_U    = 64'd1 << F;
  localparam logic [63:0] HALF_U   = ONE_U >> 1;
  localparam logic [63:0] EPS_U    = (ONE_U + 64'd500000) / 64'd1000000;
  localparam logic [63:0] NEAR1_U  = ONE_U - EPS_U;
  localparam logic [63:0] LAM_LO_U = 64'd7 * HALF_U;
  localparam logic [63:0] LAM_HI_U = ONE_U << 2;

  localparam logic signed [W-1:0] FX_HALF   = signed'(HALF_U[W-1:0]);
  localparam logic signed [W-1:0] FX_EPS    = signed'(EPS_U[W-1:0]);
  localparam logic signed [W-1:0] FX_NEAR1  = signed'(NEAR1_U[W-1:0]);
  localparam logic signed [W-1:0] FX_LAM_LO = signed'(LAM_LO_U[W-1:0]);
  localparam logic signed [W-1:0] FX_LAM_HI = signed'(LAM_HI_U[W-1:0]);
  localparam logic signed [W-1:0] FX_MAXV   = signed'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W-1:0] FX_MINV   = signed'({1'b1, {(W-1){1'b0}}});

  localparam logic signed [W:0] NEAR1_X     = signed'({1'b0, NEAR1_U[W-1:0]});
  localparam logic signed [W:0] NEG_NEAR1_X = -NEAR1_X;
  localparam logic signed [W:0] ONE_X       = signed'({1'b0, ONE_U[W-1:0]});
  localparam logic signed [W:0] MAXV_X      = signed'({2'b00, {(W-1){1'b1}}});

  dlmo_pkg::state_t state_r, state_nxt;
  dlmo_pkg::op_t    op_r, op_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [W-1:0] lam_r, lam_nxt;
  logic signed [W-1:0] seed_r, seed_nxt;
  logic signed [W-1:0] err_r, err_nxt;
  logic signed [W-1:0] second_r, second_nxt;
  logic signed [W-1:0] x1_r, x1_nxt;
  logic signed [W-1:0] x2_r, x2_nxt;
  logic signed [W-1:0] last_seed_r, last_seed_nxt;
  logic signed [W-1:0] last_offset_r, last_offset_nxt;
  logic signed [W-1:0] prod_r, prod_nxt;
  logic signed [W-1:0] opa_r, opa_nxt;
  logic signed [W-1:0] opb_r, opb_nxt;
  logic [2*H-1:0]      maga_r, maga_nxt;
  logic [2*H-1:0]      magb_r, magb_nxt;
  logic                neg_r, neg_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic signed [W-1:0] out_one_r, out_one_nxt;
  logic signed [W-1:0] out_two_r, out_two_nxt;

  logic                in_fire;
  logic                out_load;
  logic signed [W:0]   sum2;
  logic signed [W-1:0] x_sel;
  logic signed [W:0]   om_diff;
  logic signed [W-1:0] om_val;
  logic [W-1:0]        mag_a_w;
  logic [W-1:0]        mag_b_w;
  logic [H-1:0]        a_half;
  logic [H-1:0]        b_half;
  logic [2*H-1:0]      pp;
  logic [AW-1:0]       pp_shift;
  logic [QW-1:0]       q;
  logic                rem_nz;
  logic                q_over;
  logic                q_big;
  logic signed [W-1:0] res;

  assign in_ch.ready           = (state_r == dlmo_pkg::ST_IDLE);
  assign in_fire               = in_ch.valid && in_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.trajectory_one = out_one_r;
  assign out_ch.trajectory_two = out_two_r;
  assign out_load = (state_r == dlmo_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  // Second start value, computed one bit wider so that it cannot overflow.
  assign sum2 = {seed_r[W-1], seed_r} + {err_r[W-1], err_r};

  // One minus x, saturated at the top of the word.
  assign x_sel   = (op_r == dlmo_pkg::OP_TWO_SCALE) ? x2_r : x1_r;
  assign om_diff = ONE_X - {x_sel[W-1], x_sel};
  assign om_val  = (om_diff > MAXV_X) ? FX_MAXV : om_diff[W-1:0];

  assign mag_a_w = opa_r[W-1] ? unsigned'(-opa_r) : unsigned'(opa_r);
  assign mag_b_w = opb_r[W-1] ? unsigned'(-opb_r) : unsigned'(opb_r);

  // Partial product of half-width magnitude digits.
  assign a_half = cnt_r[1] ? maga_r[2*H-1:H] : maga_r[H-1:0];
  assign b_half = cnt_r[0] ? magb_r[2*H-1:H] : magb_r[H-1:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (cnt_r)
      2'd0:    pp_shift = AW'(pp);
      2'd3:    pp_shift = AW'(pp) << (2 * H);
      default: pp_shift = AW'(pp) << H;
    endcase
  end

  // Scale back by the fraction width, round towards minus infinity, saturate.
  assign q      = acc_r[AW-1:F];
  assign rem_nz = |acc_r[F-1:0];
  assign q_over = |q[QW-1:W-1];
  assign q_big  = (|q[QW-1:W]) || (q[W-1] && (|q[W-2:0]));

  always_comb begin
    if (!neg_r) begin
      res = q_over ? FX_MAXV : signed'(q[W-1:0]);
    end else if (rem_nz) begin
      res = q_over ? FX_MINV : signed'(~q[W-1:0]);
    end else begin
      res = q_big ? FX_MINV : signed'(-q[W-1:0]);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    cnt_nxt         = cnt_r;
    started_nxt     = started_r;
    out_valid_nxt   = out_valid_r;
    lam_nxt         = lam_r;
    seed_nxt        = seed_r;
    err_nxt         = err_r;
    second_nxt      = second_r;
    x1_nxt          = x1_r;
    x2_nxt          = x2_r;
    last_seed_nxt   = last_seed_r;
    last_offset_nxt = last_offset_r;
    prod_nxt        = prod_r;
    opa_nxt         = opa_r;
    opb_nxt         = opb_r;
    maga_nxt        = maga_r;
    magb_nxt        = magb_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    out_one_nxt     = out_one_r;
    out_two_nxt     = out_two_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dlmo_pkg::ST_IDLE: begin
        if (in_fire) begin
          lam_nxt   = in_ch.growth_rate;
          seed_nxt  = in_ch.start_value;
          err_nxt   = in_ch.offset_value;
          state_nxt = dlmo_pkg::ST_CLIP;
        end
      end
      dlmo_pkg::ST_CLIP: begin
        if (lam_r > FX_LAM_HI) begin
          lam_nxt = FX_LAM_HI;
        end else if (lam_r < FX_LAM_LO) begin
          lam_nxt = FX_LAM_LO;
        end
        if (seed_r > FX_NEAR1) begin
          seed_nxt = FX_NEAR1;
        end else if (seed_r < FX_EPS) begin
          seed_nxt = FX_EPS;
        end
        state_nxt = dlmo_pkg::ST_PREP;
      end
      dlmo_pkg::ST_PREP: begin
        if (sum2 > NEAR1_X) begin
          second_nxt = FX_NEAR1;
        end else if (sum2 < NEG_NEAR1_X) begin
          second_nxt = -FX_NEAR1;
        end else begin
          second_nxt = sum2[W-1:0];
        end
        if (!started_r || seed_r != last_seed_r || err_r != last_offset_r) begin
          x1_nxt = seed_r;
          x2_nxt = second_nxt;
        end
        started_nxt     = 1'b1;
        last_seed_nxt   = seed_r;
        last_offset_nxt = err_r;
        op_nxt          = dlmo_pkg::OP_ONE_RATE;
        state_nxt       = dlmo_pkg::ST_LOAD;
      end
      dlmo_pkg::ST_LOAD: begin
        case (op_r)
          dlmo_pkg::OP_ONE_RATE: begin
            opa_nxt = x1_r;
            opb_nxt = lam_r;
          end
          dlmo_pkg::OP_TWO_RATE: begin
            opa_nxt = x2_r;
            opb_nxt = lam_r;
          end
          default: begin
            opa_nxt = prod_r;
            opb_nxt = om_val;
          end
        endcase
        state_nxt = dlmo_pkg::ST_MAG;
      end
      dlmo_pkg::ST_MAG: begin
        maga_nxt  = (2 * H)'(mag_a_w);
        magb_nxt  = (2 * H)'(mag_b_w);
        neg_nxt   = opa_r[W-1] ^ opb_r[W-1];
        acc_nxt   = '0;
        cnt_nxt   = 2'd0;
        state_nxt = dlmo_pkg::ST_MUL;
      end
      dlmo_pkg::ST_MUL: begin
        acc_nxt = acc_r + pp_shift;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = dlmo_pkg::ST_FIN;
        end
      end
      dlmo_pkg::ST_FIN: begin
        case (op_r)
          dlmo_pkg::OP_ONE_SCALE: x1_nxt   = res;
          dlmo_pkg::OP_TWO_SCALE: x2_nxt   = res;
          default:                prod_nxt = res;
        endcase
        if (op_r == dlmo_pkg::OP_TWO_SCALE) begin
          state_nxt = dlmo_pkg::ST_DONE;
        end else begin
          op_nxt    = dlmo_pkg::op_t'(op_r + 2'd1);
          state_nxt = dlmo_pkg::ST_LOAD;
        end
      end
      dlmo_pkg::ST_DONE: begin
        if (out_load) begin
          out_one_nxt   = x1_r;
          out_two_nxt   = x2_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dlmo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dlmo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dlmo_pkg::ST_IDLE;
      op_r          <= dlmo_pkg::OP_ONE_RATE;
      cnt_r         <= 2'd0;
      started_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      x1_r          <= FX_HALF;
      x2_r          <= FX_HALF;
      last_seed_r   <= FX_HALF;
      last_offset_r <= '0;
    end else begin
      state_r       <= state_nxt;
      op_r          <= op_nxt;
      cnt_r         <= cnt_nxt;
      started_r     <= started_nxt;
      out_valid_r   <= out_valid_nxt;
      x1_r          <= x1_nxt;
      x2_r          <= x2_nxt;
      last_seed_r   <= last_seed_nxt;
      last_offset_r <= last_offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lam_r     <= lam_nxt;
    seed_r    <= seed_nxt;
    err_r     <= err_nxt;
    second_r  <= second_nxt;
    prod_r    <= prod_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    maga_r    <= maga_nxt;
    magb_r    <= magb_nxt;
    neg_r     <= neg_nxt;
    acc_r     <= acc_nxt;
    out_one_r <= out_one_nxt;
    out_two_r <= out_two_nxt;
  end

  // A finished item is always handed to the output register and frees the input.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (state_r == dlmo_pkg::ST_IDLE))
    else $error("finished item was not moved to the output register");

  // Every multiplication starts from a cleared accumulator at the first digit.
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dlmo_pkg::ST_MAG) |=>
      (state_r == dlmo_pkg::ST_MUL) && (cnt_r == 2'd0) && (acc_r == '0))
    else $error("multiplication did not start from a cleared accumulator");

  // An accepted beat marks the trajectories as started before any multiply.
  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ##2 started_r && (state_r == dlmo_pkg::ST_LOAD)
      && (op_r == dlmo_pkg::OP_ONE_RATE))
    else $error("beat did not start the trajectories");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the dual logistic map oscillator.
// Drives directed and random rate, seed and offset beats, predicts both trajectories
// in fixed point and checks every result beat. Needs dlmo_if.sv and the top level.

module testbench;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 28;
  localparam int ITEM_TARGET   = 700;
  localparam int CALM_TAIL     = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  localparam longint FX_ONE   = 64'sd1 <<< FRACTION_BITS;
  localparam longint FX_HALF  = FX_ONE / 2;
  localparam longint FX_EPS   = (FX_ONE + 500000) / 1000000;
  localparam longint FX_NEAR1 = FX_ONE - FX_EPS;
  localparam longint LAM_LO   = 7 * FX_HALF;
  localparam longint LAM_HI   = 4 * FX_ONE;
  localparam longint WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct {
    word_t growth_rate;
    word_t start_value;
    word_t offset_value;
  } sample_t;

  typedef struct {
    word_t trajectory_one;
    word_t trajectory_two;
  } pair_t;

  logic clk;
  logic rst_n = 1'b0;

  dlmo_in_if  #(.WORD_BITS(WORD_BITS)) in_ch ();
  dlmo_out_if #(.WORD_BITS(WORD_BITS)) out_ch ();

  dual_logistic_map_oscillator #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic    in_valid  = 1'b0;
  sample_t in_sample = '{0, 0, 0};
  logic    out_ready = 1'b0;

  assign in_ch.valid        = in_valid;
  assign in_ch.growth_rate  = in_sample.growth_rate;
  assign in_ch.start_value  = in_sample.start_value;
  assign in_ch.offset_value = in_sample.offset_value;
  assign out_ch.ready       = out_ready;

  sample_t pending_samples[$];
  pair_t   predicted_pairs[$];

  int   directed_total  = 0;
  int   item_total      = 0;
  int   accepted_count  = 0;
  int   results_checked = 0;
  int   restart_count   = 0;
  int   mismatch_count  = 0;
  int   gap_left        = 0;
  int   stall_left      = 0;
  int   cycle_count     = 0;
  logic beat_taken      = 1'b0;
  logic hold_off        = 1'b0;

  logic   osc_started     = 1'b0;
  longint osc_one         = FX_HALF;
  longint osc_two         = FX_HALF;
  longint osc_last_seed   = FX_HALF;
  word_t  osc_last_offset = '0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint saturate_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Both operands are word-sized, so the full product fits; the shift rounds down.
  function automatic longint fixed_product(longint a, longint b);
    longint p;
    p = a * b;
    return saturate_word(p >>> FRACTION_BITS);
  endfunction

  function automatic longint logistic_step(longint x, longint rate);
    longint rest;
    rest = (x < FX_ONE - WORD_MAX) ? WORD_MAX : FX_ONE - x;
    return fixed_product(fixed_product(x, rate), rest);
  endfunction

  function automatic pair_t advance_oscillator(sample_t s);
    longint rate;
    longint seed;
    longint err;
    longint second;
    pair_t  r;
    rate = s.growth_rate;
    seed = s.start_value;
    err  = s.offset_value;
    if (rate > LAM_HI) rate = LAM_HI;
    if (rate < LAM_LO) rate = LAM_LO;
    if (seed > FX_NEAR1) seed = FX_NEAR1;
    if (seed < FX_EPS) seed = FX_EPS;
    if (err > FX_NEAR1 - seed) second = FX_NEAR1;
    else if (err < -FX_NEAR1 - seed) second = -FX_NEAR1;
    else second = seed + err;
    if (!osc_started || seed != osc_last_seed || s.offset_value != osc_last_offset) begin
      osc_one = seed;
      osc_two = second;
      restart_count++;
    end
    osc_started     = 1'b1;
    osc_one         = logistic_step(osc_one, rate);
    osc_two         = logistic_step(osc_two, rate);
    osc_last_seed   = seed;
    osc_last_offset = s.offset_value;
    r.trajectory_one = word_t'(osc_one);
    r.trajectory_two = word_t'(osc_two);
    return r;
  endfunction

  task automatic queue_sample(input longint rate, input longint seed, input longint offset);
    sample_t s;
    s.growth_rate  = word_t'(rate);
    s.start_value  = word_t'(seed);
    s.offset_value = word_t'(offset);
    pending_samples.push_back(s);
  endtask

  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (rst_n && in_valid && in_ch.ready) begin
      beat_taken = 1'b1;
      predicted_pairs.push_back(advance_oscillator(in_sample));
      void'(pending_samples.pop_front());
      accepted_count++;
    end
  end

  // A beat on offer stays on offer until it is taken.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !beat_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_samples.size() >= CALM_TAIL && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= pending_samples[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (pending_samples.size() >= CALM_TAIL && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The receiver stops for a long stretch so that the block backs up onto its input.
  initial begin
    wait (accepted_count >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    pair_t want;
    if (rst_n && out_ch.valid && out_ready) begin
      if (predicted_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: one %h two %h",
                   out_ch.trajectory_one, out_ch.trajectory_two);
      end else begin
        want = predicted_pairs.pop_front();
        results_checked++;
        if (out_ch.trajectory_one !== want.trajectory_one ||
            out_ch.trajectory_two !== want.trajectory_two) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected one %h two %h, got one %h two %h",
                     results_checked, want.trajectory_one, want.trajectory_two,
                     out_ch.trajectory_one, out_ch.trajectory_two);
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int    run_len;
    int    k;
    logic  fixed_rate;
    word_t rate;
    word_t seed;
    word_t offset;

    repeat (3) queue_sample(LAM_HI, FX_HALF, 0);
    queue_sample(WORD_MAX, FX_HALF, 0);
    queue_sample(WORD_MIN, FX_HALF, 0);
    queue_sample(LAM_LO - 1, FX_HALF, 0);
    queue_sample(LAM_LO, 0, 0);
    queue_sample(LAM_HI, WORD_MIN, 0);
    queue_sample(LAM_HI, WORD_MAX, 0);
    queue_sample(LAM_HI, FX_ONE, 0);
    queue_sample(LAM_HI, FX_HALF, WORD_MAX);
    queue_sample(LAM_HI, FX_HALF, WORD_MAX - 1);
    repeat (4) queue_sample(LAM_HI, FX_HALF, WORD_MIN);
    queue_sample(LAM_LO + FX_ONE / 4, FX_EPS, -(FX_ONE / 4));
    queue_sample(LAM_HI, FX_ONE / 4, 1 << 20);
    queue_sample(WORD_MAX, FX_ONE / 4, 1 << 20);
    queue_sample(LAM_LO, FX_ONE / 4, 1 << 20);
    queue_sample((LAM_LO + LAM_HI) / 2, FX_ONE / 4, 1 << 20);
    queue_sample(LAM_HI, FX_NEAR1, -FX_NEAR1);
    queue_sample(LAM_HI, FX_EPS, FX_NEAR1);
    directed_total = pending_samples.size();

    // Mostly runs that hold seed and offset so the trajectories evolve, with some noise.
    while (pending_samples.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_sample($urandom, $urandom, $urandom);
        continue;
      end
      if ($urandom_range(0, 7) == 0) seed = $urandom;
      else seed = $urandom_range(1, FX_ONE - 1);
      case ($urandom_range(0, 3))
        0: offset = 0;
        1, 2: begin
          k = $urandom_range(0, 27);
          offset = $urandom_range(0, 1 << k);
          if ($urandom_range(0, 1) == 1) offset = -offset;
        end
        default: offset = $urandom;
      endcase
      run_len    = $urandom_range(1, 20);
      fixed_rate = ($urandom_range(0, 3) == 0);
      rate       = $urandom_range(LAM_LO, LAM_HI);
      repeat (run_len) begin
        if (!fixed_rate) begin
          if ($urandom_range(0, 15) == 0) rate = $urandom;
          else rate = $urandom_range(LAM_LO, LAM_HI);
        end
        if ($urandom_range(0, 39) == 0) offset = offset ^ 1;
        queue_sample(rate, seed, offset);
      end
    end
    item_total = pending_samples.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_samples.size() != 0 || predicted_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d beats sent (%0d directed), %0d results checked, %0d trajectory restarts.",
             item_total, directed_total, results_checked, restart_count);
    $display("Rates, seeds and offsets were clipped at both ends; %0d mismatches found.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dlmo_pkg.sv
hw/rtl/dlmo_if.sv
hw/rtl/dual_logistic_map_oscillator.sv
tb/sv/testbench.sv
